/* design/cll_pkg.sv */
// shared types and constants of the cursor linked list
package cll_pkg;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned SLOT_BITS     = $clog2(CAPACITY);
  localparam int unsigned PTR_BITS      = SLOT_BITS + 1;

  // port field widths
  localparam int unsigned IN_VALUE_BITS  = 32;
  localparam int unsigned OUT_SLOT_BITS  = 4;
  localparam int unsigned OUT_COUNT_BITS = 5;
  localparam int unsigned OUT_DATA_BITS  = 16;

  localparam logic [PTR_BITS-1:0] NO_SLOT = PTR_BITS'(CAPACITY);

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic rd_free;
    logic rd_head;
    logic del_step;
    logic app_store;
    logic app_link;
    logic del_unlink;
    logic del_free;
    logic set_full;
    logic set_miss;
    logic load_out;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic free_empty;
    logic head_none;
    logic match;
    logic next_none;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic                      store_full;
    logic [OUT_COUNT_BITS-1:0] live_count;
    logic [OUT_SLOT_BITS-1:0]  slot;
    status_e                   status;
  } out_item_t;

endpackage

/* design/cursor_linked_list_top.sv */
// Cursor linked list: a singly linked list of values kept in a slot array
// with a chain of free slots.
// Input stream: s_axis_tuser_i carries the kind (0 append at tail, 1 delete
// first match), s_axis_tdata_i the value. Every input transfer produces one
// result transfer on the m_axis side: status, slot, live count, store full.
// Items are handled one at a time. An append passes through S_APP_RD,
// S_APP_LINK and S_FINISH; a delete walks the list (1 to CAPACITY slots) in
// S_DEL_RD, then goes through S_DEL_FREE if it finds its value, and on to
// S_FINISH. The walk compares one slot per cycle through the registered read
// port of the value and link memories. An append to a full store or a delete
// on an empty list goes from its transfer straight to S_FINISH.
// The next input transfer is taken in the cycle after a result is loaded into
// the output register; a waiting result does not block the next item, only
// its own result waits until the previous one is taken.
// Reset empties the list and chains all slots free, with no clearing pass:
// unwritten links read as their reset value through per-slot valid bits.
// A stalled receiver holds the result stable in the output register.
module cursor_linked_list_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  input  logic [0:0]  s_axis_tuser_i,   // kind[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // status[1:0] slot[5:2] live_count[10:6]
                                        // store_full[11] zero[15:12]
);
  import cll_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;
  out_item_t  out_item;

  cll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i[0]),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cll_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_value_i  (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata_o = OUT_DATA_BITS'(out_item);

`ifndef SYNTHESIS
  // a failed operation reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[1:0] != ST_DONE)) |-> (m_axis_tdata_o[5:2] == '0))
    else $error("nonzero slot on failed operation");

  // the free chain is empty exactly when every slot is on the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[11] == (m_axis_tdata_o[10:6] == OUT_COUNT_BITS'(CAPACITY))))
    else $error("store full flag disagrees with live count");

  // one item at a time: an accepted item closes the input until it is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while an item is in progress");

  // live count never exceeds the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[10:6] <= OUT_COUNT_BITS'(CAPACITY)))
    else $error("live count beyond capacity");
`endif

endmodule

/* design/cll_ram.sv */
// generic single write port ram with registered read
module cll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cll_ctrl.sv */
// sequencing state machine of the cursor linked list
module cll_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  output logic                in_ready_o,
  input  cll_pkg::dp_status_t stat_i,
  output cll_pkg::ctrl_cmd_t  cmd_o
);
  import cll_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_APP_RD   = 6'b000010,
    S_APP_LINK = 6'b000100,
    S_DEL_RD   = 6'b001000,
    S_DEL_FREE = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_kind_i == KIND_APPEND) begin
            if (stat_i.free_empty) begin
              cmd_o.set_full = 1'b1;
              state_d        = S_FINISH;
            end else begin
              cmd_o.rd_free = 1'b1;
              state_d       = S_APP_RD;
            end
          end else begin
            if (stat_i.head_none) begin
              cmd_o.set_miss = 1'b1;
              state_d        = S_FINISH;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = S_DEL_RD;
            end
          end
        end
      end
      S_APP_RD: begin
        cmd_o.app_store = 1'b1;
        state_d         = S_APP_LINK;
      end
      S_APP_LINK: begin
        cmd_o.app_link = 1'b1;
        state_d        = S_FINISH;
      end
      S_DEL_RD: begin
        // one list slot compared per cycle
        if (stat_i.match) begin
          cmd_o.del_unlink = 1'b1;
          state_d          = S_DEL_FREE;
        end else if (stat_i.next_none) begin
          cmd_o.set_miss = 1'b1;
          state_d        = S_FINISH;
        end else begin
          cmd_o.del_step = 1'b1;
        end
      end
      S_DEL_FREE: begin
        cmd_o.del_free = 1'b1;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/cll_datapath.sv */
// pointers, slot memories and result register of the cursor linked list
module cll_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cll_pkg::ctrl_cmd_t                    cmd_i,
  output cll_pkg::dp_status_t                   stat_o,
  input  logic [cll_pkg::IN_VALUE_BITS-1:0]     in_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output cll_pkg::out_item_t                    out_item_o
);
  import cll_pkg::*;

  logic [PTR_BITS-1:0]   free_head_q, free_head_d;
  logic [PTR_BITS-1:0]   head_q, head_d;
  logic [PTR_BITS-1:0]   tail_q, tail_d;
  logic [PTR_BITS-1:0]   cur_q, cur_d;
  logic [PTR_BITS-1:0]   prev_q, prev_d;
  logic [PTR_BITS-1:0]   count_q, count_d;
  logic [VALUE_BITS-1:0] val_q;
  status_e               res_status_q, res_status_d;
  logic [CAPACITY-1:0]   link_vld_q, link_vld_d;
  logic [SLOT_BITS-1:0]  rd_addr_q;
  logic                  rd_vld_q;
  out_item_t             out_q;
  logic                  out_valid_q, out_valid_d;

  logic [SLOT_BITS-1:0]  raddr;
  logic                  link_we;
  logic [SLOT_BITS-1:0]  link_waddr;
  logic [PTR_BITS-1:0]   link_wdata;
  logic [PTR_BITS-1:0]   link_rdata;
  logic [PTR_BITS-1:0]   link_eff;
  logic [VALUE_BITS-1:0] value_rdata;

  // a link never written still holds its reset value, the next slot
  assign link_eff = rd_vld_q ? link_rdata
                             : (PTR_BITS'(rd_addr_q) + PTR_BITS'(1));

  assign stat_o.free_empty = (free_head_q == NO_SLOT);
  assign stat_o.head_none  = (head_q == NO_SLOT);
  assign stat_o.match      = (value_rdata == val_q);
  assign stat_o.next_none  = (link_eff == NO_SLOT);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    raddr = cur_q[SLOT_BITS-1:0];
    if (cmd_i.rd_free) begin
      raddr = free_head_q[SLOT_BITS-1:0];
    end else if (cmd_i.rd_head) begin
      raddr = head_q[SLOT_BITS-1:0];
    end else if (cmd_i.del_step) begin
      raddr = link_eff[SLOT_BITS-1:0];
    end
  end

  always_comb begin
    free_head_d  = free_head_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    link_we      = 1'b0;
    link_waddr   = cur_q[SLOT_BITS-1:0];
    link_wdata   = NO_SLOT;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (cmd_i.rd_free) begin
      cur_d = free_head_q;
    end
    if (cmd_i.rd_head) begin
      cur_d  = head_q;
      prev_d = NO_SLOT;
    end
    if (cmd_i.del_step) begin
      prev_d = cur_q;
      cur_d  = link_eff;
    end
    if (cmd_i.app_store) begin
      free_head_d = link_eff;
      link_we     = 1'b1;
      link_waddr  = cur_q[SLOT_BITS-1:0];
      link_wdata  = NO_SLOT;
    end
    if (cmd_i.app_link) begin
      if (tail_q != NO_SLOT) begin
        link_we    = 1'b1;
        link_waddr = tail_q[SLOT_BITS-1:0];
        link_wdata = cur_q;
      end else begin
        head_d = cur_q;
      end
      tail_d       = cur_q;
      count_d      = count_q + PTR_BITS'(1);
      res_status_d = ST_DONE;
    end
    if (cmd_i.del_unlink) begin
      if (prev_q != NO_SLOT) begin
        link_we    = 1'b1;
        link_waddr = prev_q[SLOT_BITS-1:0];
        link_wdata = link_eff;
      end else begin
        head_d = link_eff;
      end
      if (tail_q == cur_q) begin
        tail_d = prev_q;
      end
    end
    if (cmd_i.del_free) begin
      link_we      = 1'b1;
      link_waddr   = cur_q[SLOT_BITS-1:0];
      link_wdata   = free_head_q;
      free_head_d  = cur_q;
      count_d      = count_q - PTR_BITS'(1);
      res_status_d = ST_DONE;
    end
    if (cmd_i.set_full) begin
      res_status_d = ST_FULL;
    end
    if (cmd_i.set_miss) begin
      res_status_d = ST_MISS;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end

    link_vld_d = link_vld_q;
    if (link_we) begin
      link_vld_d[link_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      head_q       <= NO_SLOT;
      tail_q       <= NO_SLOT;
      cur_q        <= NO_SLOT;
      prev_q       <= NO_SLOT;
      count_q      <= '0;
      res_status_q <= ST_DONE;
      link_vld_q   <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      free_head_q  <= free_head_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      count_q      <= count_d;
      res_status_q <= res_status_d;
      link_vld_q   <= link_vld_d;
      rd_vld_q     <= link_vld_q[raddr];
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr;
    if (cmd_i.accept) begin
      val_q <= in_value_i[VALUE_BITS-1:0];
    end
    if (cmd_i.load_out) begin
      out_q.status     <= res_status_q;
      out_q.slot       <= (res_status_q == ST_DONE) ? OUT_SLOT_BITS'(cur_q) : '0;
      out_q.live_count <= OUT_COUNT_BITS'(count_q);
      out_q.store_full <= (free_head_q == NO_SLOT);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  cll_ram #(
    .WIDTH (PTR_BITS),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (raddr),
    .rdata_o (link_rdata)
  );

  cll_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.app_store),
    .waddr_i (cur_q[SLOT_BITS-1:0]),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (value_rdata)
  );

endmodule
